// ===== rtl/x86ild_pkg.sv =====
// types, constants and opcode-map functions for the x86 instruction length decoder
package x86ild_pkg;

    localparam logic [3:0] MAX_LENGTH = 4'd15;

    localparam logic [7:0] OP_ESCAPE  = 8'h0F;
    localparam logic [7:0] OP_ESC_38  = 8'h38;
    localparam logic [7:0] OP_ESC_3A  = 8'h3A;
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_ADSIZE = 8'h67;
    localparam logic [7:0] OP_GRP3_B  = 8'hF6;
    localparam logic [7:0] OP_GRP3_V  = 8'hF7;
    localparam logic [7:0] OP_GRP5    = 8'hFF;
    localparam logic [7:0] OP_ENTER   = 8'hC8;
    localparam logic [7:0] MODRM_C0   = 8'hC0;
    localparam logic [7:0] MODRM_C8   = 8'hC8;
    localparam logic [7:0] MODRM_D0   = 8'hD0;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_ESC    = 3'd1,
        PH_ESC3   = 3'd2,
        PH_MODRM  = 3'd3,
        PH_TAIL   = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] prefix_tally;
        logic       opsize;
        logic       addrsize;
        logic [7:0] main_opcode;
        logic [1:0] opcode_len;
        logic       modrm;
        logic       sib;
        logic [2:0] disp_len;
        logic [2:0] imm_len;
        logic [3:0] bytes_left;
        logic [3:0] length;
    } dec_state_t;

    // rectangle on the opcode map: rows lo[7:4]..hi[7:4], columns lo[3:0]..hi[3:0]
    function automatic logic in_box(input logic [7:0] op, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (op[7:4] >= lo[7:4]) && (op[7:4] <= hi[7:4]) &&
               (op[3:0] >= lo[3:0]) && (op[3:0] <= hi[3:0]);
    endfunction

    function automatic logic is_legacy_prefix(input logic [7:0] b);
        return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
               b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 ||
               b == PFX_OPSIZE || b == PFX_ADSIZE;
    endfunction

    function automatic logic one_byte_modrm(input logic [7:0] op);
        return in_box(op, 8'h00, 8'h33) || in_box(op, 8'h08, 8'h3B) ||
               in_box(op, 8'h62, 8'h63) || in_box(op, 8'h80, 8'h8F) ||
               in_box(op, 8'hC0, 8'hD1) || in_box(op, 8'hC4, 8'hC7) ||
               in_box(op, 8'hD2, 8'hD3) || in_box(op, 8'hF6, 8'hF7) ||
               in_box(op, 8'hFE, 8'hFF) || op == 8'h69 || op == 8'h6B;
    endfunction

    function automatic logic two_byte_modrm(input logic [7:0] op);
        return in_box(op, 8'h00, 8'h03) || in_box(op, 8'h10, 8'h28) ||
               in_box(op, 8'h29, 8'h2F) || in_box(op, 8'h40, 8'h7F) ||
               in_box(op, 8'h90, 8'hF7) || in_box(op, 8'h98, 8'h9F) ||
               in_box(op, 8'hAB, 8'hAF) || in_box(op, 8'hB8, 8'hBF) ||
               in_box(op, 8'hD8, 8'hFE) || in_box(op, 8'hDF, 8'hEF);
    endfunction

    function automatic logic [2:0] size_z(input logic opsize);
        return opsize ? 3'd2 : 3'd4;
    endfunction

    function automatic logic [2:0] plain_imm(input logic [7:0] op, input logic opsize);
        logic [2:0] r;
        r = 3'd0;
        if (op == OP_ENTER)
            r = 3'd3;
        else if (op == 8'h81)
            r = size_z(opsize);
        else if (in_box(op, 8'h70, 8'h7F) || in_box(op, 8'hE0, 8'hE3) || op == 8'hEB ||
                 in_box(op, 8'h04, 8'h34) || in_box(op, 8'h0C, 8'h3C) ||
                 in_box(op, 8'h80, 8'h83) || in_box(op, 8'hB0, 8'hB7) ||
                 op == 8'h6A || op == 8'h6B || op == 8'hA8 || op == 8'hC0 ||
                 op == 8'hC1 || op == 8'hCD || op == 8'hD4 || op == 8'hD5 ||
                 op == 8'hE4 || op == 8'hE6 || op == 8'hA0 || op == 8'hA2)
            r = 3'd1;
        else if (in_box(op, 8'h05, 8'h35) || in_box(op, 8'h0D, 8'h3D) || op == 8'h68 ||
                 op == 8'h69 || op == 8'hA9 || op == 8'hC7 || op == 8'hE8 ||
                 op == 8'hE9)
            r = size_z(opsize);
        else if (op == 8'hC2 || op == 8'hCA)
            r = 3'd2;
        else if (in_box(op, 8'hB8, 8'hBF) || op == 8'hA1 || op == 8'hA3)
            r = size_z(opsize);
        else if (op == 8'hEA || op == 8'h9A)
            r = opsize ? 3'd4 : 3'd6;
        return r;
    endfunction

    // group opcodes whose immediate depends on the whole modrm byte
    function automatic logic [2:0] group_imm(input logic [7:0] op, input logic [7:0] m,
                                             input logic opsize);
        logic [2:0] r;
        r = 3'd0;
        if (op == OP_GRP3_B && m == MODRM_C0)
            r = 3'd1;
        else if (op == OP_GRP3_V && m == MODRM_C0)
            r = size_z(opsize);
        else if (op == OP_GRP5 && (m == MODRM_C0 || m == MODRM_C8 || m == MODRM_D0))
            r = size_z(opsize);
        return r;
    endfunction

endpackage

// ===== rtl/x86_instruction_length_decoder_unit.sv =====
// top level of the x86 instruction length decoder: byte-serial phase machine
// Takes one code byte per request and may take a new byte every clock cycle. The
// decode state and, for a finished instruction, the output register are both
// loaded at the edge that accepts the byte, so the result is offered in the
// following cycle. A result
// appears on the byte that ends an instruction, or with too_long set on the
// fifteenth byte of an instruction that is still unfinished. Input ready only
// drops while a result sits in the output register and the sink is not ready.
// A request with restart set discards any partial instruction and starts anew.
module x86_instruction_length_decoder_unit
    import x86ild_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] total_length, [7:4] prefix_bytes, [9:8] opcode_bytes, [10] modrm_present,
    // [11] sib_present, [14:12] disp_bytes, [17:15] imm_bytes, [18] operand_16,
    // [19] address_16, [23:20] zero
    output logic [23:0] m_tdata,
    output logic [0:0]  m_tuser    // [0] too_long
);

    dec_state_t  st_reg, st_next, work;
    logic        accept;
    logic        done, cut, emit;
    logic        op_known, has_m;
    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic [2:0]  grp;
    logic        in_tail;
    logic [23:0] res_data;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // next decode state for the current byte
    always_comb
    begin
        work     = s_tuser[0] ? dec_state_t'('0) : st_reg;
        work.length = work.length + 4'd1;
        done     = 1'b0;
        op_known = 1'b0;
        has_m    = 1'b0;
        mod_f    = s_tdata[7:6];
        rm_f     = s_tdata[2:0];
        grp      = 3'd0;
        unique case (work.phase)
            PH_PREFIX:
            begin
                if (is_legacy_prefix(s_tdata))
                begin
                    work.prefix_tally = work.prefix_tally + 4'd1;
                    if (s_tdata == PFX_OPSIZE)
                        work.opsize = 1'b1;
                    if (s_tdata == PFX_ADSIZE)
                        work.addrsize = 1'b1;
                end
                else if (s_tdata == OP_ESCAPE)
                begin
                    work.opcode_len = 2'd1;
                    work.phase      = PH_ESC;
                end
                else
                begin
                    work.opcode_len  = 2'd1;
                    work.main_opcode = s_tdata;
                    has_m            = one_byte_modrm(s_tdata);
                    op_known         = 1'b1;
                end
            end
            PH_ESC:
            begin
                work.opcode_len = 2'd2;
                if (s_tdata == OP_ESC_38 || s_tdata == OP_ESC_3A)
                    work.phase = PH_ESC3;
                else
                begin
                    work.main_opcode = s_tdata;
                    has_m            = two_byte_modrm(s_tdata);
                    op_known         = 1'b1;
                end
            end
            PH_ESC3:
            begin
                work.opcode_len  = 2'd3;
                work.main_opcode = s_tdata;
                has_m            = 1'b1;
                op_known         = 1'b1;
            end
            PH_MODRM:
            begin
                if (work.addrsize)
                begin
                    work.sib = 1'b0;
                    work.disp_len = (mod_f == 2'd1) ? 3'd1 :
                        (mod_f == 2'd2 || (mod_f == 2'd0 && rm_f == 3'd6)) ? 3'd2 : 3'd0;
                end
                else
                begin
                    work.sib = (mod_f <= 2'd2) && (rm_f == 3'd4);
                    work.disp_len = (mod_f == 2'd1) ? 3'd1 :
                        (mod_f == 2'd2 || (mod_f == 2'd0 && rm_f == 3'd5)) ? 3'd4 : 3'd0;
                end
                work.imm_len = 3'd0;
                if (work.opcode_len == 2'd1)
                begin
                    grp = group_imm(work.main_opcode, s_tdata, work.opsize);
                    work.imm_len = (grp != 3'd0) ? grp
                                 : plain_imm(work.main_opcode, work.opsize);
                end
                work.bytes_left = {3'd0, work.sib} + {1'b0, work.disp_len}
                                + {1'b0, work.imm_len};
                work.phase = PH_TAIL;
                done       = (work.bytes_left == 4'd0);
            end
            default:
            begin
                if (work.bytes_left != 4'd0)
                    work.bytes_left = work.bytes_left - 4'd1;
                done = (work.bytes_left == 4'd0);
            end
        endcase

        // opcode complete: either wait for modrm or go straight to the immediate
        if (op_known)
        begin
            if (has_m)
            begin
                work.modrm = 1'b1;
                work.phase = PH_MODRM;
            end
            else
            begin
                work.imm_len = (work.opcode_len == 2'd1)
                             ? plain_imm(work.main_opcode, work.opsize) : 3'd0;
                work.bytes_left = {1'b0, work.imm_len};
                work.phase      = PH_TAIL;
                done            = (work.bytes_left == 4'd0);
            end
        end

        cut     = !done && (work.length >= MAX_LENGTH);
        emit    = done || cut;
        st_next = emit ? dec_state_t'('0) : work;
    end

    // result fields; tail-only parts read as zero when cut off earlier
    always_comb
    begin
        in_tail  = (work.phase == PH_TAIL);
        res_data = {4'd0, work.addrsize, work.opsize,
                    in_tail ? work.imm_len : 3'd0,
                    in_tail ? work.disp_len : 3'd0,
                    in_tail && work.sib,
                    work.modrm, work.opcode_len, work.prefix_tally, work.length};
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
            m_tvalid_next = emit;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= cut;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // a finished or cut instruction always leaves a fresh decode state
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (st_reg.length == 4'd0 && st_reg.phase == PH_PREFIX))
        else $error("decode state not cleared after result");

    // the tail phase is only entered with bytes still to come
    a_tail_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_TAIL) |-> (st_reg.bytes_left != 4'd0))
        else $error("tail phase with no bytes left");

    // a cut-off result always reports the maximum length
    a_cut_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[3:0] == MAX_LENGTH))
        else $error("too_long result with wrong length");

    // a partial instruction never reaches the maximum length
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.length < MAX_LENGTH)
        else $error("partial instruction length out of range");

endmodule

// ===== test/tb_x86_instruction_length_decoder_unit.sv =====
// testbench for the x86 instruction length decoder: a directed stream and random code streams checked by a scoreboard
module tb_x86_instruction_length_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import x86ild_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIRECTED_LEN = 31;
    localparam int DIRECTED_RESTART_AT = 6;
    localparam int HOT_COUNT = 22;

    // first byte sent sits in the highest slot
    localparam logic [DIRECTED_LEN-1:0][7:0] DIRECTED_CODE = {
        PFX_OPSIZE, OP_GRP3_V, MODRM_C0, 8'h11, 8'h22,
        OP_GRP5,
        OP_ESCAPE, OP_ESC_38, 8'h00, 8'h04, 8'h25,
        PFX_ADSIZE, 8'h8B, 8'h06, 8'h34, 8'h12,
        8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64,
        8'h65, PFX_OPSIZE, PFX_ADSIZE, 8'hF0, 8'hF2, 8'hF3, 8'h2E
    };

    localparam logic [10:0][7:0] PREFIX_SET = {
        8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65,
        PFX_OPSIZE, PFX_ADSIZE
    };

    // opcodes with odd immediate or modrm rules
    localparam logic [HOT_COUNT-1:0][7:0] HOT_OPCODES = {
        OP_GRP3_B, OP_GRP3_V, OP_GRP5, 8'h81, OP_ENTER, 8'hEA, 8'h9A, 8'hE8,
        8'hC2, 8'hA1, 8'hB8, 8'h8B, 8'h69, 8'h6B, 8'hC0, 8'h04,
        8'h05, 8'h80, 8'h83, 8'hC7, 8'h6A, 8'h68
    };

    localparam logic [2:0][7:0] HOT_MODRM = {MODRM_C0, MODRM_C8, MODRM_D0};

    typedef struct packed {
        logic       too_long;
        logic [3:0] pad;
        logic       address_16;
        logic       operand_16;
        logic [2:0] imm_bytes;
        logic [2:0] disp_bytes;
        logic       sib_present;
        logic       modrm_present;
        logic [1:0] opcode_bytes;
        logic [3:0] prefix_bytes;
        logic [3:0] total_length;
    } insn_len_t;

    class insn_len_scoreboard;
        phase_t     phase;
        logic [3:0] pfx_cnt;
        logic       opsize;
        logic       addrsize;
        logic [7:0] opcode;
        logic [1:0] op_len;
        logic       modrm_seen;
        logic       has_sib;
        logic [2:0] disp_len;
        logic [2:0] imm_len;
        logic [3:0] tail_left;
        logic [3:0] length;
        insn_len_t  expected[$];
        int         bytes_seen;
        int         insn_checked;
        int         cut_count;
        int         restart_count;
        int         errors;

        function new();
            clear();
            bytes_seen = 0;
            insn_checked = 0;
            cut_count = 0;
            restart_count = 0;
            errors = 0;
        endfunction

        function void clear();
            phase = PH_PREFIX;
            pfx_cnt = '0;
            opsize = 1'b0;
            addrsize = 1'b0;
            opcode = '0;
            op_len = '0;
            modrm_seen = 1'b0;
            has_sib = 1'b0;
            disp_len = '0;
            imm_len = '0;
            tail_left = '0;
            length = '0;
        endfunction

        // rectangle of the opcode map spanned by two corner opcodes
        function bit rect(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
            return op[7:4] >= lo[7:4] && op[7:4] <= hi[7:4] &&
                   op[3:0] >= lo[3:0] && op[3:0] <= hi[3:0];
        endfunction

        function bit legacy_prefix(input logic [7:0] b);
            return b inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64,
                             8'h65, PFX_OPSIZE, PFX_ADSIZE};
        endfunction

        function bit modrm_one(input logic [7:0] op);
            return rect(op, 8'h00, 8'h33) || rect(op, 8'h08, 8'h3B) ||
                   rect(op, 8'h62, 8'h63) || rect(op, 8'h80, 8'h8F) ||
                   rect(op, 8'hC0, 8'hD1) || rect(op, 8'hC4, 8'hC7) ||
                   rect(op, 8'hD2, 8'hD3) || rect(op, 8'hF6, 8'hF7) ||
                   rect(op, 8'hFE, 8'hFF) || op == 8'h69 || op == 8'h6B;
        endfunction

        function bit modrm_two(input logic [7:0] op);
            return rect(op, 8'h00, 8'h03) || rect(op, 8'h10, 8'h28) ||
                   rect(op, 8'h29, 8'h2F) || rect(op, 8'h40, 8'h7F) ||
                   rect(op, 8'h90, 8'hF7) || rect(op, 8'h98, 8'h9F) ||
                   rect(op, 8'hAB, 8'hAF) || rect(op, 8'hB8, 8'hBF) ||
                   rect(op, 8'hD8, 8'hFE) || rect(op, 8'hDF, 8'hEF);
        endfunction

        function logic [2:0] word_or_dword();
            return opsize ? 3'd2 : 3'd4;
        endfunction

        function logic [2:0] table_imm(input logic [7:0] op);
            if (op == OP_ENTER)
                return 3'd3;
            if (op == 8'h81)
                return word_or_dword();
            if (rect(op, 8'h70, 8'h7F) || rect(op, 8'hE0, 8'hE3) || op == 8'hEB ||
                rect(op, 8'h04, 8'h34) || rect(op, 8'h0C, 8'h3C) ||
                rect(op, 8'h80, 8'h83) || rect(op, 8'hB0, 8'hB7) ||
                op inside {8'h6A, 8'h6B, 8'hA8, 8'hC0, 8'hC1, 8'hCD, 8'hD4, 8'hD5,
                           8'hE4, 8'hE6, 8'hA0, 8'hA2})
                return 3'd1;
            if (rect(op, 8'h05, 8'h35) || rect(op, 8'h0D, 8'h3D) || rect(op, 8'hB8, 8'hBF) ||
                op inside {8'h68, 8'h69, 8'hA9, 8'hC7, 8'hE8, 8'hE9, 8'hA1, 8'hA3})
                return word_or_dword();
            if (op == 8'hC2 || op == 8'hCA)
                return 3'd2;
            if (op == 8'hEA || op == 8'h9A)
                return opsize ? 3'd4 : 3'd6;
            return 3'd0;
        endfunction

        // group opcodes look at the whole modrm byte
        function logic [2:0] group_imm(input logic [7:0] op, input logic [7:0] m);
            if (op == OP_GRP3_B && m == MODRM_C0)
                return 3'd1;
            if (op == OP_GRP3_V && m == MODRM_C0)
                return word_or_dword();
            if (op == OP_GRP5 && (m == MODRM_C0 || m == MODRM_C8 || m == MODRM_D0))
                return word_or_dword();
            return 3'd0;
        endfunction

        function bit finish_opcode(input bit needs_modrm);
            if (needs_modrm) begin
                modrm_seen = 1'b1;
                phase = PH_MODRM;
                return 1'b0;
            end
            imm_len = (op_len == 2'd1) ? table_imm(opcode) : 3'd0;
            tail_left = 4'(imm_len);
            phase = PH_TAIL;
            return tail_left == 4'd0;
        endfunction

        function bit finish_modrm(input logic [7:0] m);
            logic [1:0] md;
            logic [2:0] rm;
            md = m[7:6];
            rm = m[2:0];
            if (addrsize) begin
                has_sib = 1'b0;
                disp_len = (md == 2'd1) ? 3'd1 :
                           (md == 2'd2 || (md == 2'd0 && rm == 3'd6)) ? 3'd2 : 3'd0;
            end else begin
                has_sib = (md != 2'd3 && rm == 3'd4);
                disp_len = (md == 2'd1) ? 3'd1 :
                           (md == 2'd2 || (md == 2'd0 && rm == 3'd5)) ? 3'd4 : 3'd0;
            end
            imm_len = 3'd0;
            if (op_len == 2'd1) begin
                imm_len = group_imm(opcode, m);
                if (imm_len == 3'd0)
                    imm_len = table_imm(opcode);
            end
            tail_left = 4'(has_sib) + 4'(disp_len) + 4'(imm_len);
            phase = PH_TAIL;
            return tail_left == 4'd0;
        endfunction

        function void note_request(input logic [7:0] b, input logic restart);
            insn_len_t res;
            bit done;
            bit cut;
            done = 1'b0;
            bytes_seen++;
            if (restart) begin
                clear();
                restart_count++;
            end
            length = length + 4'd1;
            case (phase)
                PH_PREFIX: begin
                    if (legacy_prefix(b)) begin
                        pfx_cnt = pfx_cnt + 4'd1;
                        if (b == PFX_OPSIZE)
                            opsize = 1'b1;
                        if (b == PFX_ADSIZE)
                            addrsize = 1'b1;
                    end else if (b == OP_ESCAPE) begin
                        op_len = 2'd1;
                        phase = PH_ESC;
                    end else begin
                        op_len = 2'd1;
                        opcode = b;
                        done = finish_opcode(modrm_one(b));
                    end
                end
                PH_ESC: begin
                    op_len = 2'd2;
                    if (b == OP_ESC_38 || b == OP_ESC_3A) begin
                        phase = PH_ESC3;
                    end else begin
                        opcode = b;
                        done = finish_opcode(modrm_two(b));
                    end
                end
                PH_ESC3: begin
                    op_len = 2'd3;
                    opcode = b;
                    done = finish_opcode(1'b1);
                end
                PH_MODRM: done = finish_modrm(b);
                default: begin
                    if (tail_left != 4'd0)
                        tail_left = tail_left - 4'd1;
                    done = (tail_left == 4'd0);
                end
            endcase
            cut = !done && length >= MAX_LENGTH;
            if (done || cut) begin
                res = '0;
                res.total_length = length;
                res.prefix_bytes = pfx_cnt;
                res.opcode_bytes = op_len;
                res.modrm_present = modrm_seen;
                // parts after modrm are only known once the tail is reached
                if (phase == PH_TAIL) begin
                    res.sib_present = has_sib;
                    res.disp_bytes = disp_len;
                    res.imm_bytes = imm_len;
                end
                res.operand_16 = opsize;
                res.address_16 = addrsize;
                res.too_long = cut;
                expected.push_back(res);
                clear();
            end
        endfunction

        function string show(input insn_len_t v);
            return {$sformatf("len=%0d pfx=%0d opc=%0d modrm=%0b sib=%0b ",
                              v.total_length, v.prefix_bytes, v.opcode_bytes,
                              v.modrm_present, v.sib_present),
                    $sformatf("disp=%0d imm=%0d o16=%0b a16=%0b long=%0b pad=%h",
                              v.disp_bytes, v.imm_bytes, v.operand_16,
                              v.address_16, v.too_long, v.pad)};
        endfunction

        function void check_result(input logic [23:0] d, input logic u);
            insn_len_t got;
            insn_len_t want;
            got = {u, d};
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing pending: %s", show(got));
                return;
            end
            want = expected.pop_front();
            insn_checked++;
            if (got.too_long)
                cut_count++;
            if (got.total_length !== want.total_length || got.prefix_bytes !== want.prefix_bytes ||
                got.opcode_bytes !== want.opcode_bytes ||
                got.modrm_present !== want.modrm_present ||
                got.sib_present !== want.sib_present || got.disp_bytes !== want.disp_bytes ||
                got.imm_bytes !== want.imm_bytes || got.operand_16 !== want.operand_16 ||
                got.address_16 !== want.address_16 || got.too_long !== want.too_long ||
                got.pad !== want.pad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch on instruction %0d", insn_checked);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] code_byte
    logic [0:0]  s_tuser;   // [0] restart
    logic        m_tvalid;
    logic        m_tready;
    // [3:0] total_length, [7:4] prefix_bytes, [9:8] opcode_bytes, [10] modrm_present,
    // [11] sib_present, [14:12] disp_bytes, [17:15] imm_bytes, [18] operand_16,
    // [19] address_16, [23:20] zero
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;   // [0] too_long

    insn_len_scoreboard decode_check;
    insn_len_scoreboard stream_plan;   // mirror used only to steer the byte generator
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int pfx_goal;
    int cycle_count;

    x86_instruction_length_decoder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                decode_check.check_result(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready)
                decode_check.note_request(s_tdata, s_tuser[0]);
        end
    end

    // sink side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic [7:0] b, input logic r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= r;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic offer(input logic [7:0] b, input logic r);
        stream_plan.note_request(b, r);
        send_request(b, r);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (decode_check.pending() != 0)
            @(posedge clk);
    endtask

    // picks the next code byte so that most requests form plausible instructions
    function automatic logic [7:0] choose_byte(input bit fresh);
        phase_t     ph;
        int         pfx_seen;
        int         roll;
        logic [7:0] v;
        ph = fresh ? PH_PREFIX : stream_plan.phase;
        pfx_seen = fresh ? 0 : int'(stream_plan.pfx_cnt);
        if (fresh) begin
            roll = $urandom_range(99);
            if (roll < 4)
                pfx_goal = $urandom_range(15, 10);
            else if (roll < 60)
                pfx_goal = 0;
            else
                pfx_goal = $urandom_range(3, 1);
        end
        roll = $urandom_range(99);
        v = 8'($urandom_range(255));
        case (ph)
            PH_PREFIX: begin
                if (pfx_seen < pfx_goal) begin
                    if (roll < 25)
                        v = PFX_OPSIZE;
                    else if (roll < 45)
                        v = PFX_ADSIZE;
                    else
                        v = PREFIX_SET[4'($urandom_range(10))];
                end else if (roll < 15) begin
                    v = OP_ESCAPE;
                end else if (roll < 55) begin
                    v = HOT_OPCODES[5'($urandom_range(HOT_COUNT - 1))];
                end
            end
            PH_ESC: begin
                if (roll < 35)
                    v = (roll < 18) ? OP_ESC_38 : OP_ESC_3A;
            end
            PH_MODRM: begin
                if (roll < 30)
                    v = HOT_MODRM[2'($urandom_range(2))];
                else if (roll < 60)
                    v[2:0] = 3'($urandom_range(6, 4));
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        logic [7:0] b;
        logic       r;
        repeat (count) begin
            r = ($urandom_range(99) < 4);
            b = choose_byte(r || stream_plan.length == 4'd0);
            offer(b, r);
        end
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, decode_check.pending());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        decode_check = new();
        stream_plan = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        pfx_goal = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            offer(DIRECTED_CODE[5'(DIRECTED_LEN - 1 - i)], i == DIRECTED_RESTART_AT);
        wait_for_results();

        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 88 : 7) : 0;
            recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 88 : 7) : 0;
            if (mode == 0) begin
                send_random(100);
                // sink holds off while requests keep coming, so the input backs up
                hold_cycles = 250;
                send_random(60);
                wait_for_results();
                send_random(50);
            end else begin
                send_random(205);
            end
            wait_for_results();
        end

        repeat (10) @(posedge clk);
        $display("%0d code bytes sent, %0d instructions checked, %0d cut off as too long",
                 decode_check.bytes_seen, decode_check.insn_checked, decode_check.cut_count);
        $display("%0d restarts, %0d mismatches, under four sender/sink idling mixes",
                 decode_check.restart_count, decode_check.errors);
        if (decode_check.errors == 0 && decode_check.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== x86_instruction_length_decoder_unit.f =====
rtl/x86ild_pkg.sv
rtl/x86_instruction_length_decoder_unit.sv
test/tb_x86_instruction_length_decoder_unit.sv
